### sv/log_record_deframer_crc32_defines.svh
// Assertion macros used by the record deframer core, rldc_core.
// Needs a clock named clock and an active-high reset named reset in scope.
`ifndef LOG_RECORD_DEFRAMER_CRC32_DEFINES_SVH
`define LOG_RECORD_DEFRAMER_CRC32_DEFINES_SVH

// Same-cycle implication.
`define RLDC_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("rldc assertion failed");

// Next-cycle implication.
`define RLDC_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("rldc assertion failed");

`endif

### sv/rldc_pkg.sv
// Types, codes and CRC helpers for the record deframer.
// No dependencies; the deframer modules import this package.
package rldc_pkg;

   localparam logic [31:0] LEN_FIELD_BYTES = 32'd4;
   localparam logic [31:0] RESET_MAX_LEN   = 32'd67108864;
   localparam logic [31:0] CRC_POLY        = 32'hEDB88320;
   localparam logic [31:0] CRC_INIT        = 32'hFFFFFFFF;

   typedef enum logic [2:0] {
      ROLE_CRC     = 3'd0,
      ROLE_TYPE    = 3'd1,
      ROLE_KLEN    = 3'd2,
      ROLE_VLEN    = 3'd3,
      ROLE_KEY     = 3'd4,
      ROLE_VALUE   = 3'd5,
      ROLE_IGNORED = 3'd6
   } role_type;

   typedef enum logic [2:0] {
      ST_BUSY    = 3'd0,
      ST_GOOD    = 3'd1,
      ST_BADCRC  = 3'd2,
      ST_TOOLONG = 3'd3,
      ST_TRUNC   = 3'd4,
      ST_STOPPED = 3'd5
   } status_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_stream;
   } req_item_type;

   typedef struct packed {
      logic         valid;
      req_item_type item;
   } stage_type;

   typedef struct packed {
      logic [7:0]  byte_out;
      role_type    byte_role;
      logic [31:0] byte_index;
      logic [7:0]  record_kind;
      status_type  status;
   } rsp_item_type;

   // Reflected CRC-32, one byte.
   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   // OR a byte into lane 0..3 of a little-endian word.
   function automatic logic [31:0] insert_byte(input logic [31:0] word, input logic [7:0] b,
                                               input logic [1:0] lane);
      return word | ({24'd0, b} << {lane, 3'b000});
   endfunction

endpackage

### sv/rldc_channels.sv
// Channel interfaces: input byte, result and register write.
// No dependencies.
interface rldc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_stream;
   modport source (output valid, output data_byte, output end_of_stream, input ready);
   modport sink (input valid, input data_byte, input end_of_stream, output ready);
endinterface

interface rldc_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  byte_out;
   logic [2:0]  byte_role;
   logic [31:0] byte_index;
   logic [7:0]  record_kind;
   logic [2:0]  status;
   modport source (output valid, output byte_out, output byte_role, output byte_index,
                   output record_kind, output status, input ready);
   modport sink (input valid, input byte_out, input byte_role, input byte_index,
                 input record_kind, input status, output ready);
endinterface

interface rldc_csr_if;
   logic        valid;
   logic        ready;
   logic [31:0] data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

### sv/log_record_deframer_crc32.sv
// Log record deframer with CRC-32 check.
// req_if: one stream byte per transaction, end_of_stream flags the last byte.
// rsp_if: one result per byte: byte passed through, its role, its index in the
//   field, the record type byte and a status code (busy, good, crc
//   mismatch, length too large, truncated, stopped).
// csr_if: write of max_field_length; always ready, write only while idle.
// Path: an accepted byte goes to the input register, then its result to the
//   result register. Throughput: one byte per cycle while rsp_ready is high;
//   the per-byte CRC update and field count sit between those two registers.
// Stall: when rsp_ready is low the result register holds, the input register
//   takes one more byte if it is empty, then req_ready drops until the result is taken.
// Reset: synchronous; clears the parser to the start of a record, the limit
//   to 67108864 bytes and both registers to empty. After a stop every later
//   byte is reported as ignored until reset.
// Depends on rldc_pkg, rldc_channels, rldc_in_stage and rldc_core.
module log_record_deframer_crc32 (
   input logic        clock,
   input logic        reset,
   rldc_req_if.sink   req_if,
   rldc_rsp_if.source rsp_if,
   rldc_csr_if.sink   csr_if
);
   import rldc_pkg::*;

   req_item_type req_item;
   stage_type    stage;
   rsp_item_type rsp_item;
   logic         take;
   logic         req_ready;
   logic         rsp_valid;
   logic         csr_ready;

   assign req_item.data_byte     = req_if.data_byte;
   assign req_item.end_of_stream = req_if.end_of_stream;
   assign req_if.ready           = req_ready;

   rldc_in_stage u_in_stage (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_item  (req_item),
      .req_ready (req_ready),
      .take      (take),
      .stage     (stage)
   );

   rldc_core u_core (
      .clock     (clock),
      .reset     (reset),
      .stage     (stage),
      .take      (take),
      .csr_valid (csr_if.valid),
      .csr_data  (csr_if.data),
      .csr_ready (csr_ready),
      .rsp_ready (rsp_if.ready),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   assign csr_if.ready       = csr_ready;
   assign rsp_if.valid       = rsp_valid;
   assign rsp_if.byte_out    = rsp_item.byte_out;
   assign rsp_if.byte_role   = rsp_item.byte_role;
   assign rsp_if.byte_index  = rsp_item.byte_index;
   assign rsp_if.record_kind = rsp_item.record_kind;
   assign rsp_if.status      = rsp_item.status;

endmodule

### sv/rldc_in_stage.sv
// Input register for the record deframer: holds one accepted byte transaction.
// Depends on rldc_pkg.
module rldc_in_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  rldc_pkg::req_item_type req_item,
   output logic                 req_ready,
   input  logic                 take,
   output rldc_pkg::stage_type  stage
);
   import rldc_pkg::*;

   logic         valid_ff, valid_in;
   req_item_type item_ff, item_in;

   always_comb begin
      req_ready = !valid_ff || take;
      valid_in  = valid_ff;
      item_in   = item_ff;
      if (take) begin
         valid_in = 1'b0;
      end
      if (req_valid && req_ready) begin
         valid_in = 1'b1;
         item_in  = req_item;
      end
      stage.valid = valid_ff;
      stage.item  = item_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

endmodule

### sv/rldc_core.sv
// Record parser, CRC check and result register for the record deframer.
// Depends on rldc_pkg and log_record_deframer_crc32_defines.svh.
`include "log_record_deframer_crc32_defines.svh"

module rldc_core (
   input  logic                  clock,
   input  logic                  reset,
   input  rldc_pkg::stage_type   stage,
   output logic                  take,
   input  logic                  csr_valid,
   input  logic [31:0]           csr_data,
   output logic                  csr_ready,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output rldc_pkg::rsp_item_type rsp_item
);
   import rldc_pkg::*;

   role_type     phase_ff, phase_in;
   logic [31:0]  cnt_ff, cnt_in;
   logic [31:0]  exp_ff, exp_in;
   logic [31:0]  klen_ff, klen_in;
   logic [31:0]  vlen_ff, vlen_in;
   logic [31:0]  crc_ff, crc_in;
   logic [7:0]   kind_ff, kind_in;
   logic         halted_ff, halted_in;
   logic [31:0]  max_ff, max_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_ff, rsp_in;

   logic [7:0]   b;
   logic [31:0]  cnt_inc;
   logic [31:0]  vlen_new;
   logic         done;
   status_type   status;
   logic         hdr_phase;
   logic         rsp_stopped;
   logic         rsp_ignored;

   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;
   assign take      = stage.valid && (!rsp_valid_ff || rsp_ready);

   assign hdr_phase   = (phase_ff == ROLE_CRC) || (phase_ff == ROLE_KLEN) ||
                        (phase_ff == ROLE_VLEN);
   assign rsp_stopped = (rsp_ff.status == ST_STOPPED);
   assign rsp_ignored = (rsp_ff.byte_role == ROLE_IGNORED);

   always_comb begin
      phase_in     = phase_ff;
      cnt_in       = cnt_ff;
      exp_in       = exp_ff;
      klen_in      = klen_ff;
      vlen_in      = vlen_ff;
      crc_in       = crc_ff;
      kind_in      = kind_ff;
      halted_in    = halted_ff;
      max_in       = max_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      b            = stage.item.data_byte;
      cnt_inc      = cnt_ff + 32'd1;
      vlen_new     = insert_byte(vlen_ff, b, cnt_ff[1:0]);
      done         = 1'b0;
      status       = ST_BUSY;

      if (csr_valid) begin
         max_in = csr_data;
      end
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (take) begin
         rsp_valid_in    = 1'b1;
         rsp_in.byte_out = b;
         if (halted_ff) begin
            rsp_in.byte_role   = ROLE_IGNORED;
            rsp_in.byte_index  = 32'd0;
            rsp_in.record_kind = 8'd0;
            rsp_in.status      = ST_STOPPED;
         end else begin
            if (phase_ff != ROLE_CRC) begin
               crc_in = crc_byte(crc_ff, b);
            end
            unique case (phase_ff)
               ROLE_CRC: begin
                  exp_in = insert_byte(exp_ff, b, cnt_ff[1:0]);
                  cnt_in = cnt_inc;
                  if (cnt_inc == LEN_FIELD_BYTES) begin
                     phase_in = ROLE_TYPE;
                     cnt_in   = 32'd0;
                  end
               end
               ROLE_TYPE: begin
                  kind_in  = b;
                  phase_in = ROLE_KLEN;
                  cnt_in   = 32'd0;
               end
               ROLE_KLEN: begin
                  klen_in = insert_byte(klen_ff, b, cnt_ff[1:0]);
                  cnt_in  = cnt_inc;
                  if (cnt_inc == LEN_FIELD_BYTES) begin
                     phase_in = ROLE_VLEN;
                     cnt_in   = 32'd0;
                  end
               end
               ROLE_VLEN: begin
                  vlen_in = vlen_new;
                  cnt_in  = cnt_inc;
                  if (cnt_inc == LEN_FIELD_BYTES) begin
                     cnt_in = 32'd0;
                     if (klen_ff > max_ff || vlen_new > max_ff) begin
                        status    = ST_TOOLONG;
                        halted_in = 1'b1;
                     end else if (klen_ff != 32'd0) begin
                        phase_in = ROLE_KEY;
                     end else if (vlen_new != 32'd0) begin
                        phase_in = ROLE_VALUE;
                     end else begin
                        done = 1'b1;
                     end
                  end
               end
               ROLE_KEY: begin
                  cnt_in = cnt_inc;
                  if (cnt_inc == klen_ff) begin
                     cnt_in = 32'd0;
                     if (vlen_ff != 32'd0) begin
                        phase_in = ROLE_VALUE;
                     end else begin
                        done = 1'b1;
                     end
                  end
               end
               default: begin
                  cnt_in = cnt_inc;
                  if (cnt_inc == vlen_ff) begin
                     cnt_in = 32'd0;
                     done   = 1'b1;
                  end
               end
            endcase

            rsp_in.byte_role   = phase_ff;
            rsp_in.byte_index  = cnt_ff;
            rsp_in.record_kind = kind_in;

            if (done) begin
               if (~crc_in == exp_ff) begin
                  status = ST_GOOD;
               end else begin
                  status    = ST_BADCRC;
                  halted_in = 1'b1;
               end
               phase_in = ROLE_CRC;
               cnt_in   = 32'd0;
               exp_in   = 32'd0;
               klen_in  = 32'd0;
               vlen_in  = 32'd0;
               crc_in   = CRC_INIT;
               kind_in  = 8'd0;
            end
            if (stage.item.end_of_stream) begin
               if (status == ST_BUSY) begin
                  status = ST_TRUNC;
               end
               halted_in = 1'b1;
            end
            rsp_in.status = status;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= ROLE_CRC;
         cnt_ff       <= 32'd0;
         exp_ff       <= 32'd0;
         klen_ff      <= 32'd0;
         vlen_ff      <= 32'd0;
         crc_ff       <= CRC_INIT;
         kind_ff      <= 8'd0;
         halted_ff    <= 1'b0;
         max_ff       <= RESET_MAX_LEN;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         cnt_ff       <= cnt_in;
         exp_ff       <= exp_in;
         klen_ff      <= klen_in;
         vlen_ff      <= vlen_in;
         crc_ff       <= crc_in;
         kind_ff      <= kind_in;
         halted_ff    <= halted_in;
         max_ff       <= max_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   `RLDC_ASSERT_NEXT(a_halt_sticky, halted_ff, halted_ff)
   `RLDC_ASSERT_NOW(a_hdr_count, hdr_phase, cnt_ff < LEN_FIELD_BYTES)
   `RLDC_ASSERT_NOW(a_kind_clear, phase_ff == ROLE_CRC, kind_ff == 8'd0)
   `RLDC_ASSERT_NOW(a_stop_role, rsp_valid_ff, rsp_stopped == rsp_ignored)

endmodule
